/* rtl/vtq_pkg.sv */
package vtq_pkg;

    localparam int SLOT_W = 3;
    localparam int AMT_W  = 63;
    localparam int FUNC_W = 3;
    localparam int KIND_W = 2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [AMT_W-1:0]  t_amount;
    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_func FUNC_TICK    = 3'd0;
    localparam t_func FUNC_ADD_ONE = 3'd1;
    localparam t_func FUNC_ADD_PER = 3'd2;
    localparam t_func FUNC_MOD     = 3'd3;
    localparam t_func FUNC_MOD_PER = 3'd4;
    localparam t_func FUNC_DEL     = 3'd5;

    localparam t_kind KIND_REPLY = 2'd0;
    localparam t_kind KIND_FIRE  = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    // Operation token that walks down the row of slot cells.
    typedef struct packed {
        logic    valid;
        t_func   func;
        t_slot   slot;
        t_amount amount;
        logic    reject;   // refused before entering the row
        logic    err;      // refused by the addressed cell
        logic    was;      // addressed slot was pending beforehand
        logic    fire;     // the cell that just passed the token fired
        logic    any;      // min_cnt holds a pending count
        t_amount min_cnt;  // running minimum over the cells already folded
    } t_token;

    // Settled state of one cell, seen by its downstream neighbor.
    typedef struct packed {
        logic    pend;
        t_amount cnt;
    } t_link;

endpackage

/* rtl/vtq_cell.sv */
module vtq_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vtq_pkg::t_token i_tok,
    input  vtq_pkg::t_link  i_up,
    output vtq_pkg::t_token o_tok,
    output vtq_pkg::t_link  o_link
);
    import vtq_pkg::*;

    localparam bit ADDRESSABLE = (IDX < (1 << SLOT_W));

    logic    r_pend;
    t_amount r_cnt;
    t_amount r_reload;
    t_token  r_tok;

    logic    n_pend;
    t_amount n_cnt;
    t_amount n_reload;
    t_token  n_tok;
    logic    hit;

    always_comb begin
        n_tok       = i_tok;
        n_tok.fire  = 1'b0;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_reload    = r_reload;
        hit         = ADDRESSABLE && (i_tok.func != FUNC_TICK) && !i_tok.reject &&
                      (i_tok.slot == t_slot'(IDX));

        // The upstream cell has already applied this word, so its state is final.
        if (i_up.pend && (!i_tok.any || (i_up.cnt < i_tok.min_cnt))) begin
            n_tok.any     = 1'b1;
            n_tok.min_cnt = i_up.cnt;
        end

        if (i_tok.valid) begin
            if (i_tok.func == FUNC_TICK) begin
                if (r_pend) begin
                    if (r_cnt < i_tok.amount) begin
                        n_tok.fire = 1'b1;
                        if (r_reload != '0) begin
                            n_cnt = r_reload;
                        end else begin
                            n_pend = 1'b0;
                        end
                    end else begin
                        n_cnt = r_cnt - i_tok.amount;
                    end
                end
            end else if (hit) begin
                case (i_tok.func) inside
                    FUNC_ADD_ONE, FUNC_ADD_PER: begin
                        if (r_pend) begin
                            n_tok.err = 1'b1;
                        end else begin
                            n_pend   = 1'b1;
                            n_cnt    = i_tok.amount;
                            n_reload = (i_tok.func == FUNC_ADD_PER) ? i_tok.amount : '0;
                        end
                    end
                    FUNC_MOD, FUNC_MOD_PER: begin
                        n_tok.was = r_pend;
                        if (r_pend) begin
                            // An unchanged count leaves the interval alone too.
                            if (r_cnt != i_tok.amount) begin
                                n_cnt = i_tok.amount;
                                if (i_tok.func == FUNC_MOD_PER) begin
                                    n_reload = i_tok.amount;
                                end
                            end
                        end else begin
                            n_pend   = 1'b1;
                            n_cnt    = i_tok.amount;
                            n_reload = (i_tok.func == FUNC_MOD_PER) ? i_tok.amount : '0;
                        end
                    end
                    FUNC_DEL: begin
                        n_tok.was = r_pend;
                        n_pend    = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_reload <= n_reload;
    end

    assign o_tok       = r_tok;
    assign o_link.pend = r_pend;
    assign o_link.cnt  = r_cnt;

endmodule

/* rtl/virtual_timer_queue.sv */
// A word enters the slot row in the cycle after it is accepted and moves one cell per cycle;
// fire words leave in slot order, and the closing word is registered after the token
// leaves the last cell. A new word is taken only once the operation token of the previous
// word has walked through the row of slot cells.
// Reset clears all pending flags and the busy flag, and sets max_slice to its largest value.
// Results are shown for one cycle each; the receiver cannot stall them.
module virtual_timer_queue #(
    parameter int SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  vtq_pkg::t_func        i_func,
    input  vtq_pkg::t_slot        i_slot,
    input  vtq_pkg::t_amount      i_amount,
    input  logic                  i_cfg_we,
    input  vtq_pkg::t_amount      i_cfg_wdata,
    output logic                  o_strobe,
    output vtq_pkg::t_kind        o_kind,
    output vtq_pkg::t_slot        o_fired_slot,
    output logic                  o_was_pending,
    output vtq_pkg::t_amount      o_next_deadline,
    output logic                  o_last
);
    import vtq_pkg::*;

    t_amount r_max_slice;
    logic    r_busy;
    t_token  r_head;
    logic    r_sum_valid;
    t_kind   r_sum_kind;
    t_slot   r_sum_slot;
    logic    r_sum_was;
    t_amount r_sum_dl;

    t_token  chain_tok [SLOTS+1];
    t_link   chain_link [SLOTS+1];

    logic    accept;
    logic    tail_valid;
    logic    n_busy;
    t_token  n_head;
    logic    fold_any;
    t_amount fold_min;
    t_kind   n_sum_kind;
    t_slot   n_sum_slot;
    logic    n_sum_was;
    t_amount n_sum_dl;
    logic    fire_any;
    t_slot   fire_slot;
    logic [SLOTS:0] chain_valid;

    assign tail_valid = chain_tok[SLOTS].valid;
    assign busy       = r_busy && !tail_valid;
    assign accept     = start && !busy;
    assign n_busy     = accept ? 1'b1 : (tail_valid ? 1'b0 : r_busy);

    always_comb begin
        n_head         = '0;
        n_head.valid   = accept;
        n_head.func    = i_func;
        n_head.slot    = i_slot;
        n_head.amount  = i_amount;
        if (i_func != FUNC_TICK) begin
            // Unknown codes and absent slots are refused first; a delete ignores amount.
            n_head.reject = (i_func > FUNC_DEL) || (int'(i_slot) >= SLOTS) ||
                            ((i_func != FUNC_DEL) &&
                             ((i_amount == '0) || (i_amount > r_max_slice)));
        end
    end

    assign chain_tok[0]  = r_head;
    assign chain_link[0] = '0;

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        vtq_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (chain_tok[k]),
            .i_up   (chain_link[k]),
            .o_tok  (chain_tok[k+1]),
            .o_link (chain_link[k+1])
        );
    end

    // Fold the last cell into the minimum and build the closing word.
    always_comb begin
        fold_any = chain_tok[SLOTS].any;
        fold_min = chain_tok[SLOTS].min_cnt;
        if (chain_link[SLOTS].pend && (!fold_any || (chain_link[SLOTS].cnt < fold_min))) begin
            fold_any = 1'b1;
            fold_min = chain_link[SLOTS].cnt;
        end
        n_sum_dl   = fold_any ? fold_min : r_max_slice;
        n_sum_kind = KIND_REPLY;
        n_sum_slot = '0;
        n_sum_was  = 1'b0;
        if (chain_tok[SLOTS].func != FUNC_TICK) begin
            n_sum_slot = chain_tok[SLOTS].slot;
            if (chain_tok[SLOTS].reject || chain_tok[SLOTS].err) begin
                n_sum_kind = KIND_ERROR;
            end else begin
                n_sum_was = chain_tok[SLOTS].was;
            end
        end
    end

    // Only one token is in the row, so at most one cell reports a fire per cycle.
    always_comb begin
        fire_any  = 1'b0;
        fire_slot = '0;
        for (int k = 1; k <= SLOTS; k++) begin
            if (chain_tok[k].valid && chain_tok[k].fire) begin
                fire_any  = 1'b1;
                fire_slot = t_slot'(k - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_slice  <= '1;
            r_busy       <= 1'b0;
            r_head.valid <= 1'b0;
            r_sum_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_slice <= i_cfg_wdata;
            end
            r_busy      <= n_busy;
            r_head      <= n_head;
            r_sum_valid <= tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_kind <= n_sum_kind;
        r_sum_slot <= n_sum_slot;
        r_sum_was  <= n_sum_was;
        r_sum_dl   <= n_sum_dl;
    end

    always_comb begin
        o_strobe = r_sum_valid || fire_any;
        if (r_sum_valid) begin
            o_kind          = r_sum_kind;
            o_fired_slot    = r_sum_slot;
            o_was_pending   = r_sum_was;
            o_next_deadline = r_sum_dl;
            o_last          = 1'b1;
        end else begin
            o_kind          = KIND_FIRE;
            o_fired_slot    = fire_slot;
            o_was_pending   = 1'b0;
            o_next_deadline = '0;
            o_last          = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k <= SLOTS; k++) begin
            chain_valid[k] = chain_tok[k].valid;
        end
    end

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(chain_valid))
        else $error("more than one operation token in the slot row");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sum_valid && fire_any))
        else $error("fire word collides with closing word");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_head.valid && r_busy))
        else $error("accepted word did not enter the slot row");

    a_busy_while_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_valid[SLOTS-1:0] != '0) |-> busy)
        else $error("busy dropped while a token is in the slot row");

    a_sum_follows_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_valid |-> $past(tail_valid))
        else $error("closing word without a token leaving the row");
`endif

endmodule

/* sim/tb_virtual_timer_queue.sv */
module tb_virtual_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import vtq_pkg::*;

    localparam int NUM_SLOTS = 8;
    localparam t_amount SLICE_TOP = {AMT_W{1'b1}};
    // Function codes that the block does not define.
    localparam t_func FUNC_BAD_LO = 3'd6;
    localparam t_func FUNC_BAD_HI = 3'd7;

    typedef struct {
        logic    is_cfg;
        t_func   func;
        t_slot   slot;
        t_amount amount;
        int      gap_pct;
    } t_cmd;

    typedef struct {
        t_kind   kind;
        t_slot   slot;
        logic    was;
        t_amount deadline;
        logic    last;
    } t_word;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start = 1'b0;
    logic    busy;
    t_func   i_func = FUNC_TICK;
    t_slot   i_slot = '0;
    t_amount i_amount = '0;
    logic    i_cfg_we = 1'b0;
    t_amount i_cfg_wdata = '0;
    logic    o_strobe;
    t_kind   o_kind;
    t_slot   o_fired_slot;
    logic    o_was_pending;
    t_amount o_next_deadline;
    logic    o_last;

    virtual_timer_queue #(
        .SLOTS(NUM_SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_slot(i_slot),
        .i_amount(i_amount),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe(o_strobe),
        .o_kind(o_kind),
        .o_fired_slot(o_fired_slot),
        .o_was_pending(o_was_pending),
        .o_next_deadline(o_next_deadline),
        .o_last(o_last)
    );

    // Shadow copy of the timer slots and the slice register.
    logic    slot_armed[NUM_SLOTS];
    t_amount slot_count[NUM_SLOTS];
    t_amount slot_reload[NUM_SLOTS];
    t_amount slice_limit;

    t_cmd  cmd_q[$];
    t_word due_words[$];
    int    sent_cnt = 0;
    int    accepted_cnt = 0;
    int    fail_cnt = 0;
    int    fire_cnt = 0;
    int    error_cnt = 0;
    int    gap_left = 0;
    int    quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_amount soonest_deadline();
        t_amount best;
        logic    found;
        best = slice_limit;
        found = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (slot_armed[k] && (!found || slot_count[k] < best)) begin
                best = slot_count[k];
                found = 1'b1;
            end
        end
        return best;
    endfunction

    function automatic void push_word(t_kind kind, t_slot slot, logic was, t_amount deadline,
                                      logic last);
        t_word w;
        w.kind = kind;
        w.slot = slot;
        w.was = was;
        w.deadline = deadline;
        w.last = last;
        due_words.push_back(w);
    endfunction

    function automatic void advance_timers(t_func f, t_slot s, t_amount a);
        logic was;
        if (f == FUNC_TICK) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (slot_armed[k]) begin
                    if (slot_count[k] < a) begin
                        push_word(KIND_FIRE, t_slot'(k), 1'b0, '0, 1'b0);
                        if (slot_reload[k] != '0)
                            slot_count[k] = slot_reload[k];
                        else
                            slot_armed[k] = 1'b0;
                    end else begin
                        slot_count[k] = slot_count[k] - a;
                    end
                end
            end
            push_word(KIND_REPLY, '0, 1'b0, soonest_deadline(), 1'b1);
        end else if (f > FUNC_DEL || int'(s) >= NUM_SLOTS) begin
            push_word(KIND_ERROR, s, 1'b0, soonest_deadline(), 1'b1);
        end else if (f == FUNC_DEL) begin
            was = slot_armed[s];
            slot_armed[s] = 1'b0;
            push_word(KIND_REPLY, s, was, soonest_deadline(), 1'b1);
        end else if (a == '0 || a > slice_limit) begin
            push_word(KIND_ERROR, s, 1'b0, soonest_deadline(), 1'b1);
        end else if (f == FUNC_ADD_ONE || f == FUNC_ADD_PER) begin
            if (slot_armed[s]) begin
                push_word(KIND_ERROR, s, 1'b0, soonest_deadline(), 1'b1);
            end else begin
                slot_armed[s] = 1'b1;
                slot_count[s] = a;
                slot_reload[s] = (f == FUNC_ADD_PER) ? a : '0;
                push_word(KIND_REPLY, s, 1'b0, soonest_deadline(), 1'b1);
            end
        end else if (slot_armed[s]) begin
            // An unchanged count leaves the interval alone, even for a periodic modify.
            if (slot_count[s] != a) begin
                slot_count[s] = a;
                if (f == FUNC_MOD_PER)
                    slot_reload[s] = a;
            end
            push_word(KIND_REPLY, s, 1'b1, soonest_deadline(), 1'b1);
        end else begin
            slot_armed[s] = 1'b1;
            slot_count[s] = a;
            slot_reload[s] = (f == FUNC_MOD_PER) ? a : '0;
            push_word(KIND_REPLY, s, 1'b0, soonest_deadline(), 1'b1);
        end
    endfunction

    function automatic void check_field(string name, logic [AMT_W-1:0] want,
                                        logic [AMT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void add_cmd(t_func f, t_slot s, t_amount a, int pct);
        t_cmd c;
        c.is_cfg = 1'b0;
        c.func = f;
        c.slot = s;
        c.amount = a;
        c.gap_pct = pct;
        cmd_q.push_back(c);
    endfunction

    function automatic void add_cfg(t_amount value);
        t_cmd c;
        c.is_cfg = 1'b1;
        c.func = FUNC_TICK;
        c.slot = '0;
        c.amount = value;
        c.gap_pct = 0;
        cmd_q.push_back(c);
    endfunction

    // Expiry values lean toward small counts so that ticks fire often, with the
    // boundaries of the slice register and full-width values mixed in.
    function automatic t_amount rand_amount(t_amount ms);
        logic [63:0] wide;
        int          r;
        t_amount     lim;
        wide = {$urandom, $urandom};
        r = $urandom_range(99);
        lim = (ms < 40) ? ms : 40;
        if (r < 5)
            return '0;
        else if (r < 10)
            return ms;
        else if (r < 15)
            return (ms == SLICE_TOP) ? wide[AMT_W-1:0] : ms + 1'b1;
        else if (r < 27)
            return wide[AMT_W-1:0];
        else
            return t_amount'($urandom_range(1, 32'(lim)));
    endfunction

    function automatic void add_random(t_amount ms, int count, int pct);
        int    r;
        t_func f;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 28)
                f = FUNC_TICK;
            else if (r < 43)
                f = FUNC_ADD_ONE;
            else if (r < 58)
                f = FUNC_ADD_PER;
            else if (r < 70)
                f = FUNC_MOD;
            else if (r < 80)
                f = FUNC_MOD_PER;
            else if (r < 92)
                f = FUNC_DEL;
            else
                f = ($urandom_range(1) != 0) ? FUNC_BAD_HI : FUNC_BAD_LO;
            if (f == FUNC_TICK && $urandom_range(99) < 60)
                add_cmd(f, t_slot'($urandom_range(7)), t_amount'($urandom_range(45)), pct);
            else
                add_cmd(f, t_slot'($urandom_range(7)), rand_amount(ms), pct);
        end
    endfunction

    // Driver: presents one command word at a time and holds it until it is taken.
    always @(negedge i_clk) begin : drive_proc
        logic nxt_start;
        logic nxt_we;
        t_cmd head;
        nxt_start = start;
        nxt_we = 1'b0;
        if (due_words.size() == 0 && !busy && !start && accepted_cnt == sent_cnt)
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!(start && accepted_cnt != sent_cnt)) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_q.size() > 0) begin
                head = cmd_q[0];
                if (head.is_cfg) begin
                    // The slice register only changes once the slot row has gone quiet.
                    if (quiet_cycles >= NUM_SLOTS + 4) begin
                        nxt_we = 1'b1;
                        i_cfg_wdata <= head.amount;
                        void'(cmd_q.pop_front());
                        quiet_cycles = 0;
                    end
                end else begin
                    nxt_start = 1'b1;
                    i_func <= head.func;
                    i_slot <= head.slot;
                    i_amount <= head.amount;
                    sent_cnt++;
                    void'(cmd_q.pop_front());
                    gap_left = ($urandom_range(99) < head.gap_pct) ?
                               $urandom_range(1, 2 * NUM_SLOTS + 2) : 0;
                end
            end
        end
        start <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // Monitor: checks each result word, then tracks register writes and accepted commands.
    always @(posedge i_clk) begin : watch_proc
        t_word want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (o_kind == KIND_FIRE)
                    fire_cnt++;
                if (o_kind == KIND_ERROR)
                    error_cnt++;
                if (due_words.size() == 0) begin
                    $error("result word with nothing expected: kind %0d slot %0d",
                           o_kind, o_fired_slot);
                    fail_cnt++;
                end else begin
                    want = due_words.pop_front();
                    check_field("kind", AMT_W'(want.kind), AMT_W'(o_kind));
                    check_field("fired_slot", AMT_W'(want.slot), AMT_W'(o_fired_slot));
                    check_field("was_pending", AMT_W'(want.was), AMT_W'(o_was_pending));
                    check_field("next_deadline", want.deadline, o_next_deadline);
                    check_field("last", AMT_W'(want.last), AMT_W'(o_last));
                end
            end
            if (i_cfg_we)
                slice_limit = i_cfg_wdata;
            if (start && !busy) begin
                advance_timers(i_func, i_slot, i_amount);
                accepted_cnt++;
            end
        end
    end

    initial begin
        t_amount mid_slice;
        i_rst_n = 1'b0;
        slice_limit = SLICE_TOP;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_armed[k] = 1'b0;
            slot_count[k] = '0;
            slot_reload[k] = '0;
        end

        // Directed part at the reset value of the slice register.
        add_cmd(FUNC_TICK, 0, '0, 0);
        add_cmd(FUNC_DEL, 0, '0, 0);
        add_cmd(FUNC_MOD, 0, '0, 0);
        add_cmd(FUNC_ADD_ONE, 0, '0, 0);
        add_cmd(FUNC_ADD_ONE, 1, SLICE_TOP, 0);
        add_cmd(FUNC_ADD_PER, 7, 5, 0);
        add_cmd(FUNC_ADD_ONE, 7, 3, 0);
        add_cmd(FUNC_ADD_ONE, 2, 10, 0);
        add_cmd(FUNC_MOD, 2, 10, 0);
        add_cmd(FUNC_MOD_PER, 2, 10, 0);
        add_cmd(FUNC_MOD, 7, 6, 0);
        add_cmd(FUNC_BAD_LO, 3, 1, 0);
        add_cmd(FUNC_BAD_HI, 4, SLICE_TOP, 0);
        add_cmd(FUNC_MOD_PER, 3, 4, 0);
        add_cmd(FUNC_MOD, 4, 2, 0);
        // A count equal to the elapsed time reaches zero without firing.
        add_cmd(FUNC_TICK, 5, 2, 0);
        add_cmd(FUNC_TICK, 0, 3, 0);
        add_cmd(FUNC_TICK, 0, 9, 0);
        add_cmd(FUNC_TICK, 0, SLICE_TOP, 0);
        add_cmd(FUNC_DEL, 3, '0, 0);
        add_cmd(FUNC_DEL, 7, '0, 0);
        add_cmd(FUNC_ADD_ONE, 6, 1, 0);
        add_cmd(FUNC_TICK, 0, '0, 0);
        add_cmd(FUNC_TICK, 0, 1, 0);

        add_cfg(100);
        add_random(100, 26, 49);
        add_cfg(1);
        add_random(1, 16, 0);
        add_cfg(SLICE_TOP);
        add_random(SLICE_TOP, 30, 26);
        mid_slice = t_amount'({$urandom_range(255), $urandom}) | 1'b1;
        add_cfg(mid_slice);
        add_random(mid_slice, 24, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cmd_q.size() != 0 || start || accepted_cnt != sent_cnt || due_words.size() != 0)
            @(posedge i_clk);
        repeat (2 * NUM_SLOTS + 4) @(posedge i_clk);

        $display("Ran %0d commands and ticks across five max_slice settings.", accepted_cnt);
        $display("Observed %0d slot fires and %0d command errors.", fire_cnt, error_cnt);
        if (fail_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
